// ===== hdl/variable_step_sequencer_core_macros.svh =====
// Assertion macros shared by the variable step sequencer RTL.
`ifndef VARIABLE_STEP_SEQUENCER_CORE_MACROS_SVH
`define VARIABLE_STEP_SEQUENCER_CORE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define VSS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define VSS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define VSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vss_pkg.sv =====
// Shared types, constants and helpers of the variable step sequencer.
`default_nettype none

package vss_pkg;

    // Default number of duration table slots.
    localparam int unsigned STEP_SLOTS_DEF = 16;

    // Field widths.
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned DUR_W     = 16;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned TOTAL_W   = 16;

    // Stream word widths, padded up to whole bytes.
    localparam int unsigned S_FIELDS_W = NOW_W + DELTA_W + IDX_W + DUR_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_FIELDS_W = STEP_W + ELAPSED_W + TOTAL_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Step count after reset.
    localparam logic [CFG_W-1:0] STEP_COUNT_RST = 5'd16;

    // Back-off window of the phase move: half the timestamp range.
    localparam logic [NOW_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

    // Quotient bits retired per cycle by the remainder unit.
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;

    // Operation codes carried in the input word's user field.
    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE       = 3'd0,
        OP_RESET_PHASE   = 3'd1,
        OP_SET_STEP      = 3'd2,
        OP_MOVE_PHASE    = 3'd3,
        OP_LOAD_DURATION = 3'd4
    } op_t;

    // A zero duration counts as one tick so that a walk always ends.
    function automatic logic [DUR_W-1:0] eff_dur(input logic [DUR_W-1:0] d);
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/variable_step_sequencer_core.sv =====
// Top level of the variable step sequencer: control sequencer around the duration table.
`default_nettype none

// The sequencer keeps the current step and the start time of that step in registers and the
// per-step durations in a single-port-read table memory. Each input word carries an operation
// in tuser and yields exactly one result word: the step, the elapsed time in the cycle and the
// cycle total. One word is worked on at a time. Every operation ends with a sweep over the n
// active table entries through the memory read port and a state that forms the result. An
// advance also walks steps, each with a read state and a compare state, sweeps the table
// once more for the cycle length and runs the remainder unit to skip whole cycles. A phase
// move adds one sweep and, while the new start lies after now, one pass through the remainder
// unit in front of that. A new word is taken while the previous result still waits in the
// output register. The table has no reset; a duration slot must be loaded before any
// operation reads it.

`include "variable_step_sequencer_core_macros.svh"

module variable_step_sequencer_core #(
    parameter int unsigned STEP_SLOTS = vss_pkg::STEP_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Step count register.
    input  wire logic                          cfg_we,
    input  wire logic [vss_pkg::CFG_W-1:0]     cfg_wdata,
    // Input words.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // now [31:0], delta [47:32], entry_index [51:48], duration_value [67:52], zero pad
    input  wire logic [vss_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [2:0]
    input  wire logic [vss_pkg::OP_W-1:0]      s_tuser,
    // Result words.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // step_index [3:0], elapsed_in_cycle [19:4], cycle_total [35:20], zero pad
    output logic      [vss_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned SW    = $clog2(STEP_SLOTS);
    localparam int unsigned CW    = $clog2(STEP_SLOTS + 1);
    localparam int unsigned KW    = (CW > vss_pkg::CFG_W) ? CW : vss_pkg::CFG_W;
    localparam int unsigned TW    = vss_pkg::DUR_W + SW;
    localparam int unsigned NW    = vss_pkg::NOW_W;
    localparam int unsigned DW    = vss_pkg::DUR_W;
    localparam int unsigned M_PAD = vss_pkg::M_TDATA_W - vss_pkg::M_FIELDS_W;

    localparam int unsigned DELTA_LO = NW;
    localparam int unsigned IDX_LO   = DELTA_LO + vss_pkg::DELTA_W;
    localparam int unsigned DUR_LO   = IDX_LO + vss_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_SUM,
        ST_MV_NS,
        ST_MV_DIV,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SUM_ADV,
        SUM_MOVE,
        SUM_RES
    } sum_use_t;

    typedef enum logic {
        DIV_ADV,
        DIV_MOVE
    } div_use_t;

    // Active step count, clamped to one through the number of slots.
    function automatic logic [CW-1:0] clamp_count(input logic [vss_pkg::CFG_W-1:0] sc);
        logic [KW-1:0] v;
        v = KW'(sc);
        if (v == '0) begin
            v = KW'(1);
        end else if (v > KW'(STEP_SLOTS)) begin
            v = KW'(STEP_SLOTS);
        end
        return CW'(v);
    endfunction

    // Input word fields.
    vss_pkg::op_t                 in_op;
    logic [NW-1:0]                in_now;
    logic signed [vss_pkg::DELTA_W-1:0] in_delta;
    logic [vss_pkg::IDX_W-1:0]    in_idx;
    logic [DW-1:0]                in_dur;
    logic                         in_acc;

    assign in_op    = vss_pkg::op_t'(s_tuser);
    assign in_now   = s_tdata[NW-1:0];
    assign in_delta = s_tdata[IDX_LO-1:DELTA_LO];
    assign in_idx   = s_tdata[DUR_LO-1:IDX_LO];
    assign in_dur   = s_tdata[DUR_LO+DW-1:DUR_LO];
    assign in_acc   = s_tvalid && s_tready;

    // Control state.
    state_t                     state_reg, state_next;
    sum_use_t                   sum_use_reg, sum_use_next;
    div_use_t                   div_use_reg, div_use_next;
    logic [vss_pkg::CFG_W-1:0]  count_reg, count_next;
    logic [SW-1:0]              cur_reg, cur_next;
    logic [NW-1:0]              start_reg, start_next;
    logic [CW-1:0]              sum_idx_reg, sum_idx_next;
    logic                       pend_vld_reg, pend_vld_next;
    logic                       m_valid_reg, m_valid_next;

    // Word payload and sweep accumulators.
    logic [NW-1:0]                      now_reg, now_next;
    logic signed [vss_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [SW-1:0]                      pend_idx_reg, pend_idx_next;
    logic [TW-1:0]                      tot_reg, tot_next;
    logic [DW-1:0]                      sum16_reg, sum16_next;
    logic [DW-1:0]                      pre16_reg, pre16_next;
    logic [vss_pkg::STEP_W-1:0]         m_step_reg, m_step_next;
    logic [vss_pkg::ELAPSED_W-1:0]      m_el_reg, m_el_next;
    logic [vss_pkg::TOTAL_W-1:0]        m_tot_reg, m_tot_next;

    // Memory and remainder unit hookup.
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [SW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic [TW-1:0] div_divisor;
    logic          div_busy;
    logic          div_done;
    logic [TW-1:0] div_rem;

    // Shared datapath terms.
    logic [CW-1:0] n_act;
    logic [NW-1:0] el_now;
    logic [NW-1:0] mv_d;
    logic [DW-1:0] d_eff;
    logic [DW-1:0] so16;
    logic          cur_wrap;
    logic          sum_issue;
    logic [SW-1:0] cur_chk;
    logic          sweep_go;
    sum_use_t      sweep_use;

    assign n_act     = clamp_count(count_reg);
    assign el_now    = now_reg - start_reg;
    assign mv_d      = start_reg - now_reg;
    assign d_eff     = vss_pkg::eff_dur(mem_rdata);
    assign so16      = pre16_reg + el_now[DW-1:0];
    assign cur_wrap  = (CW'(cur_reg) + CW'(1)) == n_act;
    assign sum_issue = sum_idx_reg < n_act;
    assign cur_chk   = (KW'(cur_reg) >= KW'(n_act)) ? '0 : cur_reg;

    // Table loads are written as the word is taken.
    assign mem_we    = in_acc && (in_op == vss_pkg::OP_LOAD_DURATION)
                       && (KW'(in_idx) < KW'(STEP_SLOTS));
    assign mem_waddr = SW'(in_idx);
    assign mem_wdata = vss_pkg::eff_dur(in_dur);

    vss_dur_mem #(
        .STEP_SLOTS(STEP_SLOTS)
    ) u_dur_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vss_rem #(
        .DVS_W(TW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        sum_use_next  = sum_use_reg;
        div_use_next  = div_use_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        sum_idx_next  = sum_idx_reg;
        pend_vld_next = 1'b0;
        now_next      = now_reg;
        delta_next    = delta_reg;
        pend_idx_next = pend_idx_reg;
        tot_next      = tot_reg;
        sum16_next    = sum16_reg;
        pre16_next    = pre16_reg;
        m_step_next   = m_step_reg;
        m_el_next     = m_el_reg;
        m_tot_next    = m_tot_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        mem_raddr     = cur_reg;
        div_start     = 1'b0;
        div_dividend  = el_now;
        div_divisor   = tot_reg;
        div_use_next  = div_use_reg;
        sweep_go      = 1'b0;
        sweep_use     = SUM_RES;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    now_next   = in_now;
                    delta_next = in_delta;
                    case (in_op)
                        vss_pkg::OP_ADVANCE: begin
                            cur_next = cur_chk;
                            if (cur_chk != '0) begin
                                state_next = ST_WALK_RD;
                            end else begin
                                sweep_go  = 1'b1;
                                sweep_use = SUM_ADV;
                            end
                        end
                        vss_pkg::OP_RESET_PHASE: begin
                            start_next = in_now;
                            cur_next   = '0;
                            sweep_go   = 1'b1;
                        end
                        vss_pkg::OP_SET_STEP: begin
                            cur_next = (KW'(in_idx) < KW'(n_act)) ? SW'(in_idx) : '0;
                            sweep_go = 1'b1;
                        end
                        vss_pkg::OP_MOVE_PHASE: begin
                            sweep_go  = 1'b1;
                            sweep_use = SUM_MOVE;
                        end
                        default: begin
                            // Loads and unknown codes only report.
                            sweep_go = 1'b1;
                        end
                    endcase
                end
            end

            ST_WALK_RD: begin
                mem_raddr  = cur_reg;
                state_next = ST_WALK_EV;
            end

            // Take one step if its duration has gone by.
            ST_WALK_EV: begin
                if (el_now >= NW'(d_eff)) begin
                    start_next = start_reg + NW'(d_eff);
                    if (cur_wrap) begin
                        cur_next  = '0;
                        sweep_go  = 1'b1;
                        sweep_use = SUM_ADV;
                    end else begin
                        cur_next   = cur_reg + SW'(1);
                        state_next = ST_WALK_RD;
                    end
                end else begin
                    sweep_go = 1'b1;
                end
            end

            // Sweep the active entries: full cycle length, wrapped sum and prefix sum.
            ST_SUM: begin
                mem_raddr     = sum_idx_reg[SW-1:0];
                pend_vld_next = sum_issue;
                pend_idx_next = sum_idx_reg[SW-1:0];
                if (sum_issue) begin
                    sum_idx_next = sum_idx_reg + CW'(1);
                end
                if (pend_vld_reg) begin
                    tot_next   = tot_reg + TW'(d_eff);
                    sum16_next = sum16_reg + mem_rdata;
                    if (pend_idx_reg < cur_reg) begin
                        pre16_next = pre16_reg + mem_rdata;
                    end
                end
                if (!sum_issue && !pend_vld_reg) begin
                    case (sum_use_reg)
                        SUM_ADV: begin
                            div_start    = 1'b1;
                            div_dividend = el_now;
                            div_divisor  = tot_reg;
                            div_use_next = DIV_ADV;
                            state_next   = ST_DIV_WAIT;
                        end
                        SUM_MOVE: begin
                            state_next = ST_MV_NS;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // New step start before back-off: now minus phase minus delta.
            ST_MV_NS: begin
                start_next = now_reg - NW'(so16)
                             - {{(NW - vss_pkg::DELTA_W){delta_reg[vss_pkg::DELTA_W-1]}},
                                delta_reg};
                cur_next   = '0;
                state_next = ST_MV_DIV;
            end

            // Back off whole cycles while the start lies after now.
            ST_MV_DIV: begin
                if ((sum16_reg != '0) && (mv_d < vss_pkg::HALF_RANGE)) begin
                    div_start    = 1'b1;
                    div_dividend = mv_d;
                    div_divisor  = TW'(sum16_reg);
                    div_use_next = DIV_MOVE;
                    state_next   = ST_DIV_WAIT;
                end else begin
                    sweep_go  = 1'b1;
                    sweep_use = SUM_ADV;
                end
            end

            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (div_use_reg)
                        DIV_ADV: begin
                            // Skip whole cycles, then walk the remaining steps.
                            start_next = now_reg - NW'(div_rem);
                            state_next = ST_WALK_RD;
                        end
                        default: begin
                            start_next = now_reg + NW'(div_rem) - NW'(sum16_reg);
                            sweep_go   = 1'b1;
                            sweep_use  = SUM_ADV;
                        end
                    endcase
                end
            end

            // Load the result once the output register is free.
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_step_next  = vss_pkg::STEP_W'(cur_reg);
                    m_el_next    = so16;
                    m_tot_next   = sum16_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a table sweep.
        if (sweep_go) begin
            state_next    = ST_SUM;
            sum_use_next  = sweep_use;
            sum_idx_next  = '0;
            pend_vld_next = 1'b0;
            tot_next      = '0;
            sum16_next    = '0;
            pre16_next    = '0;
        end

        // Step count writes must arrive only while idle; the block itself does not enforce it.
        if (cfg_we) begin
            count_next = cfg_wdata;
            if (KW'(cur_reg) >= KW'(clamp_count(cfg_wdata))) begin
                cur_next = '0;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_use_reg  <= SUM_RES;
            div_use_reg  <= DIV_ADV;
            count_reg    <= vss_pkg::STEP_COUNT_RST;
            cur_reg      <= '0;
            start_reg    <= '0;
            sum_idx_reg  <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_use_reg  <= sum_use_next;
            div_use_reg  <= div_use_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            start_reg    <= start_next;
            sum_idx_reg  <= sum_idx_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        delta_reg    <= delta_next;
        pend_idx_reg <= pend_idx_next;
        tot_reg      <= tot_next;
        sum16_reg    <= sum16_next;
        pre16_reg    <= pre16_next;
        m_step_reg   <= m_step_next;
        m_el_reg     <= m_el_next;
        m_tot_reg    <= m_tot_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, m_tot_reg, m_el_reg, m_step_reg};

    // The current step never leaves the active range.
    `VSS_ASSERT_ALWAYS(a_step_in_range, aclk, aresetn, KW'(cur_reg) < KW'(n_act), "step out of range")
    // Once a word is taken, the next one waits until the result is formed.
    `VSS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word taken")
    // Table writes happen only as a word is taken in the idle state.
    `VSS_ASSERT_IMPLY(a_load_idle, aclk, aresetn, mem_we, state_reg == ST_IDLE, "table write while busy")
    // The remainder unit is never restarted while it works.
    `VSS_ASSERT_IMPLY(a_div_free, aclk, aresetn, div_start, !div_busy, "remainder unit restarted")
    // A result appears only after the sequencer finished a word.
    `VSS_ASSERT_IMPLY(a_result_src, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_DONE), "stray result")

endmodule

`default_nettype wire

// ===== hdl/vss_dur_mem.sv =====
// Duration table: one write port, one read port with registered read data.
`default_nettype none

module vss_dur_mem #(
    parameter int unsigned STEP_SLOTS = vss_pkg::STEP_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [$clog2(STEP_SLOTS)-1:0] waddr,
    input  wire logic [vss_pkg::DUR_W-1:0]     wdata,
    input  wire logic [$clog2(STEP_SLOTS)-1:0] raddr,
    output logic      [vss_pkg::DUR_W-1:0]     rdata
);

    logic [vss_pkg::DUR_W-1:0] dur_mem [STEP_SLOTS];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            dur_mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        rdata <= dur_mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/vss_rem.sv =====
// Iterative remainder unit: 32-bit dividend, narrow divisor, two bits a cycle.
`default_nettype none

module vss_rem #(
    parameter int unsigned DVS_W = 20
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [vss_pkg::NOW_W-1:0] dividend,
    input  wire logic [DVS_W-1:0]          divisor,
    output logic                           busy,
    output logic                           done,
    output logic      [DVS_W-1:0]          remainder
);

    localparam int unsigned STEPS = vss_pkg::DIV_BITS_PER_CYCLE;
    localparam int unsigned ITER  = vss_pkg::NOW_W / STEPS;
    localparam int unsigned CNT_W = $clog2(ITER);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [vss_pkg::NOW_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0]          rem_reg, rem_next;
    logic [DVS_W-1:0]          dvs_reg, dvs_next;
    logic [DVS_W-1:0]          rem_step;
    logic [vss_pkg::NOW_W-1:0] quo_step;

    // Restoring remainder steps: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        logic [DVS_W:0]          trial;
        logic [DVS_W-1:0]        r;
        logic [vss_pkg::NOW_W-1:0] q;
        r     = rem_reg;
        q     = quo_reg;
        trial = '0;
        for (int i = 0; i < STEPS; i++) begin
            trial = {r, q[vss_pkg::NOW_W-1]};
            if (trial >= {1'b0, dvs_reg}) begin
                trial = trial - {1'b0, dvs_reg};
            end
            r = trial[DVS_W-1:0];
            q = {q[vss_pkg::NOW_W-2:0], 1'b0};
        end
        rem_step = r;
        quo_step = q;
    end

    // Sequencing of the iterations.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
